// ----- rtl/core/rdnss_pkg.sv -----
// Shared types and constants for the RDNSS option parser.
// Holds result codes, header offsets, walk modes and the queue entry format.
// No dependencies.
package rdnss_pkg;

  // Default depth of the message window (byte offset saturates here)
  localparam int MAX_MSG_BYTES_DEF = 8192;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_USER_MSG_TYPE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DNS_OPT_TYPE  = 1'd1;
  localparam logic [15:0] DEF_USER_MSG_TYPE = 16'd68;
  localparam logic [7:0]  DEF_DNS_OPT_TYPE  = 8'd25;

  // Protocol constants
  localparam logic [7:0] FAMILY_INET6       = 8'd10;
  localparam logic [7:0] ICMP_ROUTER_ADVERT = 8'd134;
  localparam logic [7:0] ICMP_CODE_NONE     = 8'd0;

  // Header byte offsets
  localparam int OPTIONS_BASE = 32;
  localparam logic [4:0] OFS_MSG_TYPE_HI = 5'd5;
  localparam logic [4:0] OFS_FAMILY      = 5'd16;
  localparam logic [4:0] OFS_OPT_LEN_LO  = 5'd18;
  localparam logic [4:0] OFS_OPT_LEN_HI  = 5'd19;
  localparam logic [4:0] OFS_ICMP_TYPE   = 5'd24;
  localparam logic [4:0] OFS_ICMP_CODE   = 5'd25;

  // Result kinds
  localparam logic [1:0] KIND_OPTION = 2'd0;
  localparam logic [1:0] KIND_ADDR   = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  // Message status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_WRONG_TYPE = 3'd1;
  localparam logic [2:0] ST_NOT_RA     = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_STRAY      = 3'd4;
  localparam logic [2:0] ST_ZERO_LEN   = 3'd5;

  // Queue between parser front and result back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_WALK,
    MODE_STOPPED,
    MODE_REJECT
  } walk_mode_t;

  typedef struct packed {
    logic [15:0] user_msg_type;
    logic [7:0]  dns_type;
  } rdnss_cfg_t;

  // Work for the back end caused by one byte: an optional option or
  // address result, then an optional done status.
  typedef struct packed {
    logic        has_evt;
    logic        evt_is_addr;
    logic [7:0]  opt_type;
    logic [10:0] opt_bytes;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [31:0] lifetime;
    logic        has_done;
    logic [2:0]  done_status;
  } rdnss_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  option_type;
    logic [10:0] option_bytes;
    logic [63:0] address_high;
    logic [63:0] address_low;
    logic [31:0] lifetime_seconds;
    logic [2:0]  status;
    logic        run_last;
  } rdnss_result_t;

endpackage

// ----- rtl/core/rdnss_if.sv -----
// Valid/ready channel interfaces for the RDNSS option parser.
// Byte input channel and result output channel; no dependencies.
interface rdnss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

interface rdnss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  option_type;
  logic [10:0] option_bytes;
  logic [63:0] address_high;
  logic [63:0] address_low;
  logic [31:0] lifetime_seconds;
  logic [2:0]  status;
  logic        run_last;

  modport source (output valid, kind, option_type, option_bytes, address_high,
                  address_low, lifetime_seconds, status, run_last, input ready);
  modport sink (input valid, kind, option_type, option_bytes, address_high,
                address_low, lifetime_seconds, status, run_last, output ready);
endinterface

// ----- rtl/core/ra_rdnss_option_parser_core.sv -----
// Each byte's results are written into the queue by the edge that accepts
// the byte and then loaded from it into the output register; a byte with
// an option or address result and a done status gives its second result as
// a further beat. Throughput: one byte per cycle while results are taken; a
// four-entry queue absorbs the extra output beat of message-ending bytes.
// Reset (rst_n low, synchronous) clears control state; message type 68, DNS type 25.
module ra_rdnss_option_parser_core #(
  parameter int MAX_MSG_BYTES = rdnss_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  rdnss_in_if.sink                         in_bus,
  rdnss_out_if.source                      out_bus,
  input  logic                             cfg_we,
  input  logic [rdnss_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rdnss_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  rdnss_pkg::rdnss_cfg_t    cfg_r, cfg_nxt;
  rdnss_pkg::rdnss_entry_t  push_entry, pop_entry;
  rdnss_pkg::rdnss_result_t out_res;
  logic                     push_valid, push_ready;
  logic                     pop_valid, pop;

  // Write configuration registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rdnss_pkg::CFG_USER_MSG_TYPE: cfg_nxt.user_msg_type = cfg_wdata[15:0];
        rdnss_pkg::CFG_DNS_OPT_TYPE:  cfg_nxt.dns_type      = cfg_wdata[7:0];
        default:                      cfg_nxt               = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.user_msg_type <= rdnss_pkg::DEF_USER_MSG_TYPE;
      cfg_r.dns_type      <= rdnss_pkg::DEF_DNS_OPT_TYPE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  rdnss_front #(
    .MAX_MSG_BYTES (MAX_MSG_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_bus.valid),
    .in_ready   (in_bus.ready),
    .in_byte    (in_bus.data_byte),
    .in_eom     (in_bus.end_of_message),
    .cfg        (cfg_r),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  rdnss_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  rdnss_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .out_res   (out_res)
  );

  // Drive result channel fields
  assign out_bus.kind             = out_res.kind;
  assign out_bus.option_type      = out_res.option_type;
  assign out_bus.option_bytes     = out_res.option_bytes;
  assign out_bus.address_high     = out_res.address_high;
  assign out_bus.address_low      = out_res.address_low;
  assign out_bus.lifetime_seconds = out_res.lifetime_seconds;
  assign out_bus.status           = out_res.status;
  assign out_bus.run_last         = out_res.run_last;

endmodule

// ----- rtl/core/rdnss_front.sv -----
// Parser front end: takes one message byte a beat, tracks header and option
// walk state, and pushes the results of each byte into the queue.
// Depends on rdnss_pkg.
module rdnss_front #(
  parameter int MAX_MSG_BYTES = rdnss_pkg::MAX_MSG_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_eom,
  input  rdnss_pkg::rdnss_cfg_t    cfg,
  input  logic                     push_ready,
  output logic                     push_valid,
  output rdnss_pkg::rdnss_entry_t  push_entry
);

  localparam int OFF_W = $clog2(MAX_MSG_BYTES + 1);
  localparam int CW    = ((OFF_W > 17) ? OFF_W : 17) + 1;

  // Parse state
  logic [OFF_W-1:0]      off_r, off_nxt;
  logic [31:0]           decl_len_r, decl_len_nxt;
  logic [15:0]           msg_type_r, msg_type_nxt;
  logic [15:0]           opt_len_r, opt_len_nxt;
  logic [7:0]            family_r, family_nxt;
  logic [7:0]            icmp_type_r, icmp_type_nxt;
  rdnss_pkg::walk_mode_t mode_r, mode_nxt;
  logic [OFF_W-1:0]      opt_start_r, opt_start_nxt;
  logic [7:0]            cur_type_r, cur_type_nxt;
  logic [10:0]           cur_bytes_r, cur_bytes_nxt;
  logic [31:0]           lifetime_r, lifetime_nxt;
  logic [63:0]           addr_hi_r, addr_hi_nxt;
  logic [63:0]           addr_lo_r, addr_lo_nxt;
  logic [2:0]            status_r, status_nxt;

  logic            accept;
  logic            in_range;
  logic            in_hdr_window;
  logic [4:0]      hdr_ofs;
  logic [CW-1:0]   o_ext, end_ext, start_ext, rel_w, nb_end;
  logic [10:0]     rel;
  logic [10:0]     nb;
  logic            is_dns;
  logic            rel_last;
  logic [15:0]     msg_type_full;
  rdnss_pkg::rdnss_entry_t entry;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;

  // Offsets and option-region arithmetic
  assign in_range      = off_r < OFF_W'(MAX_MSG_BYTES);
  assign in_hdr_window = off_r < OFF_W'(rdnss_pkg::OPTIONS_BASE);
  assign hdr_ofs       = off_r[4:0];
  assign o_ext         = CW'(off_r);
  assign end_ext       = CW'(opt_len_r) + CW'(rdnss_pkg::OPTIONS_BASE);
  assign start_ext     = CW'(opt_start_r);
  assign rel_w         = o_ext - start_ext;
  assign rel           = rel_w[10:0];
  assign nb            = {in_byte, 3'b000};
  assign nb_end        = start_ext + CW'(nb);
  assign msg_type_full = {in_byte, msg_type_r[7:0]};
  assign is_dns        = (cur_type_r == cfg.dns_type) && (cur_bytes_r[10:3] >= 8'd3) &&
                         cur_bytes_r[3];
  assign rel_last      = (12'(rel) + 12'd1) >= 12'(cur_bytes_r);

  // Next state and queue entry for the byte on the input
  always_comb begin
    off_nxt       = off_r;
    decl_len_nxt  = decl_len_r;
    msg_type_nxt  = msg_type_r;
    opt_len_nxt   = opt_len_r;
    family_nxt    = family_r;
    icmp_type_nxt = icmp_type_r;
    mode_nxt      = mode_r;
    opt_start_nxt = opt_start_r;
    cur_type_nxt  = cur_type_r;
    cur_bytes_nxt = cur_bytes_r;
    lifetime_nxt  = lifetime_r;
    addr_hi_nxt   = addr_hi_r;
    addr_lo_nxt   = addr_lo_r;
    status_nxt    = status_r;
    entry         = '0;

    if (accept) begin
      if (in_range && mode_r == rdnss_pkg::MODE_HEADER && in_hdr_window) begin
        // Collect header fields; check them at the type and code bytes
        if (hdr_ofs < 5'd4) begin
          decl_len_nxt = decl_len_r | (32'(in_byte) << {hdr_ofs[1:0], 3'b000});
        end else if (hdr_ofs < rdnss_pkg::OFS_MSG_TYPE_HI) begin
          msg_type_nxt = {msg_type_r[15:8], in_byte};
        end else if (hdr_ofs == rdnss_pkg::OFS_MSG_TYPE_HI) begin
          msg_type_nxt = msg_type_full;
          if (msg_type_full != cfg.user_msg_type) begin
            status_nxt = rdnss_pkg::ST_WRONG_TYPE;
            mode_nxt   = rdnss_pkg::MODE_REJECT;
          end
        end else if (hdr_ofs == rdnss_pkg::OFS_FAMILY) begin
          family_nxt = in_byte;
        end else if (hdr_ofs == rdnss_pkg::OFS_OPT_LEN_LO) begin
          opt_len_nxt = {opt_len_r[15:8], in_byte};
        end else if (hdr_ofs == rdnss_pkg::OFS_OPT_LEN_HI) begin
          opt_len_nxt = {in_byte, opt_len_r[7:0]};
        end else if (hdr_ofs == rdnss_pkg::OFS_ICMP_TYPE) begin
          icmp_type_nxt = in_byte;
        end else if (hdr_ofs == rdnss_pkg::OFS_ICMP_CODE) begin
          if (family_r != rdnss_pkg::FAMILY_INET6 ||
              icmp_type_r != rdnss_pkg::ICMP_ROUTER_ADVERT ||
              in_byte != rdnss_pkg::ICMP_CODE_NONE) begin
            status_nxt = rdnss_pkg::ST_NOT_RA;
            mode_nxt   = rdnss_pkg::MODE_REJECT;
          end else if (33'(end_ext) > 33'(decl_len_r) ||
                       end_ext > CW'(MAX_MSG_BYTES)) begin
            status_nxt = rdnss_pkg::ST_TRUNCATED;
            mode_nxt   = rdnss_pkg::MODE_REJECT;
          end else begin
            opt_start_nxt = OFF_W'(rdnss_pkg::OPTIONS_BASE);
            mode_nxt      = rdnss_pkg::MODE_WALK;
          end
        end
      end else if (in_range && mode_r == rdnss_pkg::MODE_WALK && !in_hdr_window) begin
        // Walk the type-length options
        if (o_ext >= end_ext || start_ext >= end_ext) begin
          mode_nxt = rdnss_pkg::MODE_STOPPED;
        end else if (rel == 11'd0) begin
          cur_type_nxt  = in_byte;
          cur_bytes_nxt = '0;
          if (o_ext + CW'(1) >= end_ext) begin
            status_nxt = rdnss_pkg::ST_STRAY;
            mode_nxt   = rdnss_pkg::MODE_STOPPED;
          end
        end else if (rel == 11'd1) begin
          cur_bytes_nxt = nb;
          if (nb == 11'd0) begin
            status_nxt = rdnss_pkg::ST_ZERO_LEN;
            mode_nxt   = rdnss_pkg::MODE_STOPPED;
          end else if (nb_end > end_ext) begin
            status_nxt = rdnss_pkg::ST_STRAY;
            mode_nxt   = rdnss_pkg::MODE_STOPPED;
          end else begin
            entry.has_evt   = 1'b1;
            entry.opt_type  = cur_type_r;
            entry.opt_bytes = nb;
          end
        end else begin
          if (is_dns) begin
            if (rel >= 11'd4 && rel <= 11'd7) begin
              lifetime_nxt = {lifetime_r[23:0], in_byte};
            end else if (rel >= 11'd8) begin
              addr_hi_nxt = {addr_hi_r[55:0], addr_lo_r[63:56]};
              addr_lo_nxt = {addr_lo_r[55:0], in_byte};
              // last byte of each 16-byte address
              if (rel[3:0] == 4'd7) begin
                entry.has_evt     = 1'b1;
                entry.evt_is_addr = 1'b1;
                entry.opt_type    = cur_type_r;
                entry.opt_bytes   = cur_bytes_r;
                entry.addr_hi     = {addr_hi_r[55:0], addr_lo_r[63:56]};
                entry.addr_lo     = {addr_lo_r[55:0], in_byte};
                entry.lifetime    = lifetime_r;
              end
            end
          end
          if (rel_last) begin
            opt_start_nxt = OFF_W'(start_ext + CW'(cur_bytes_r));
          end
        end
      end

      if (in_eom) begin
        // Close the message and return to reset state
        entry.has_done = 1'b1;
        case (mode_nxt)
          rdnss_pkg::MODE_HEADER: entry.done_status = rdnss_pkg::ST_TRUNCATED;
          rdnss_pkg::MODE_WALK: begin
            entry.done_status = (o_ext + CW'(1) < end_ext) ? rdnss_pkg::ST_TRUNCATED
                                                           : rdnss_pkg::ST_OK;
          end
          default: entry.done_status = status_nxt;
        endcase
        off_nxt       = '0;
        decl_len_nxt  = '0;
        msg_type_nxt  = '0;
        opt_len_nxt   = '0;
        family_nxt    = '0;
        icmp_type_nxt = '0;
        mode_nxt      = rdnss_pkg::MODE_HEADER;
        opt_start_nxt = '0;
        cur_type_nxt  = '0;
        cur_bytes_nxt = '0;
        lifetime_nxt  = '0;
        addr_hi_nxt   = '0;
        addr_lo_nxt   = '0;
        status_nxt    = '0;
      end else if (in_range) begin
        off_nxt = off_r + OFF_W'(1);
      end
    end
  end

  assign push_valid = accept && (entry.has_evt || entry.has_done);
  assign push_entry = entry;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      decl_len_r  <= '0;
      msg_type_r  <= '0;
      opt_len_r   <= '0;
      family_r    <= '0;
      icmp_type_r <= '0;
      mode_r      <= rdnss_pkg::MODE_HEADER;
      opt_start_r <= '0;
      cur_type_r  <= '0;
      cur_bytes_r <= '0;
      lifetime_r  <= '0;
      addr_hi_r   <= '0;
      addr_lo_r   <= '0;
      status_r    <= '0;
    end else begin
      off_r       <= off_nxt;
      decl_len_r  <= decl_len_nxt;
      msg_type_r  <= msg_type_nxt;
      opt_len_r   <= opt_len_nxt;
      family_r    <= family_nxt;
      icmp_type_r <= icmp_type_nxt;
      mode_r      <= mode_nxt;
      opt_start_r <= opt_start_nxt;
      cur_type_r  <= cur_type_nxt;
      cur_bytes_r <= cur_bytes_nxt;
      lifetime_r  <= lifetime_nxt;
      addr_hi_r   <= addr_hi_nxt;
      addr_lo_r   <= addr_lo_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule

// ----- rtl/core/rdnss_fifo.sv -----
// Short queue of per-byte work between the parser front and the result back.
// Depends on rdnss_pkg for the entry format and depth.
module rdnss_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push_valid,
  output logic                     push_ready,
  input  rdnss_pkg::rdnss_entry_t  push_entry,
  output logic                     pop_valid,
  input  logic                     pop,
  output rdnss_pkg::rdnss_entry_t  pop_entry
);

  localparam int CNT_W = $clog2(rdnss_pkg::QUEUE_DEPTH + 1);
  localparam int PTR_W = rdnss_pkg::QPTR_W;

  rdnss_pkg::rdnss_entry_t          mem_r [rdnss_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]                 wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]                 rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]                 count_r, count_nxt;
  logic                             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(rdnss_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ----- rtl/core/rdnss_back.sv -----
// Result back end: expands each queued entry into one or two result beats
// and holds them in the output register until taken. Depends on rdnss_pkg.
module rdnss_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     pop_valid,
  input  rdnss_pkg::rdnss_entry_t  pop_entry,
  output logic                     pop,
  input  logic                     out_ready,
  output logic                     out_valid,
  output rdnss_pkg::rdnss_result_t out_res
);

  logic                     out_valid_r, out_valid_nxt;
  logic                     phase_r, phase_nxt;
  rdnss_pkg::rdnss_result_t res_r, res_nxt;
  logic                     load;
  logic                     emit_evt;

  assign load     = pop_valid && (!out_valid_r || out_ready);
  assign emit_evt = pop_entry.has_evt && !phase_r;

  // Pick the next beat of the head entry
  always_comb begin
    res_nxt       = res_r;
    phase_nxt     = phase_r;
    pop           = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      if (emit_evt) begin
        res_nxt.kind             = pop_entry.evt_is_addr ? rdnss_pkg::KIND_ADDR
                                                         : rdnss_pkg::KIND_OPTION;
        res_nxt.option_type      = pop_entry.opt_type;
        res_nxt.option_bytes     = pop_entry.opt_bytes;
        res_nxt.address_high     = pop_entry.addr_hi;
        res_nxt.address_low      = pop_entry.addr_lo;
        res_nxt.lifetime_seconds = pop_entry.lifetime;
        res_nxt.run_last         = !pop_entry.has_done;
        phase_nxt                = pop_entry.has_done;
        pop                      = !pop_entry.has_done;
      end else begin
        res_nxt.kind     = rdnss_pkg::KIND_DONE;
        res_nxt.status   = pop_entry.done_status;
        res_nxt.run_last = 1'b1;
        phase_nxt        = 1'b0;
        pop              = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// ----- rtl/core/rdnss_checker.sv -----
// Port-level checks on the result channel of the RDNSS option parser,
// bound to the top level. Depends on rdnss_pkg for result codes.
module rdnss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  option_type,
  input logic [10:0] option_bytes,
  input logic [63:0] address_high,
  input logic [63:0] address_low,
  input logic [31:0] lifetime_seconds,
  input logic [2:0]  status,
  input logic        run_last
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(status) &&
      $stable(address_low) && $stable(run_last))
    else $error("result beat changed while stalled");

  // A done status always closes the run of its byte
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == rdnss_pkg::KIND_DONE |->
      run_last && option_type == 8'd0 && option_bytes == 11'd0)
    else $error("done status malformed");

  // An option report carries a nonzero whole-unit length and no payload
  a_option_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == rdnss_pkg::KIND_OPTION |->
      option_bytes != 11'd0 && option_bytes[2:0] == 3'd0 && status == 3'd0 &&
      address_high == 64'd0 && address_low == 64'd0 && lifetime_seconds == 32'd0)
    else $error("option report malformed");

  // An address only comes from an odd length of at least three units
  a_addr_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == rdnss_pkg::KIND_ADDR |->
      option_bytes[3] && option_bytes[10:3] >= 8'd3 && status == 3'd0)
    else $error("address from malformed option");

endmodule

bind ra_rdnss_option_parser_core rdnss_checker u_rdnss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .kind             (out_bus.kind),
  .option_type      (out_bus.option_type),
  .option_bytes     (out_bus.option_bytes),
  .address_high     (out_bus.address_high),
  .address_low      (out_bus.address_low),
  .lifetime_seconds (out_bus.lifetime_seconds),
  .status           (out_bus.status),
  .run_last         (out_bus.run_last)
);
